// File: src/mpqe_pkg.sv
// ----------------------------------------------------------------------------
// Message pool queue engine package
// Action codes and field widths shared by the engine.
// ----------------------------------------------------------------------------
`default_nettype none
package mpqe_pkg;
    localparam logic [2:0] ACT_ALLOC = 3'd0;
    localparam logic [2:0] ACT_FREE  = 3'd1;
    localparam logic [2:0] ACT_ENQ   = 3'd2;
    localparam logic [2:0] ACT_PUSH  = 3'd3;
    localparam logic [2:0] ACT_POP   = 3'd4;
    localparam logic [2:0] ACT_PEEK  = 3'd5;
    localparam logic [2:0] ACT_QUERY = 3'd6;
    localparam logic [2:0] ACT_QRST  = 3'd7;

    localparam int ACTION_BITS = 3;
    localparam int QID_BITS    = 3;
    localparam int SLOT_BITS   = 5;
    localparam int SENDER_W    = 8;
    localparam int PAYLOAD_W   = 32;
endpackage
`default_nettype wire

// File: src/message_pool_queue_engine.sv
// Sequence: every accepted beat passes ST_READ and ST_EXEC; free, peek, query, queue
// reset, a failed alloc and an enqueue or push onto an empty queue then go on to
// ST_RDOUT and ST_OUT; a successful alloc and an enqueue or push next to a neighbor
// pass ST_FIX first; a pop walks ST_EXEC and ST_WALK per entry, up to MSG_SLOTS. One item
// at a time: the next beat is taken only once the result beat is accepted and back in ST_IDLE.
// Reset (aresetn low, synchronous) clears the control state: full stack, empty queues.
// ----------------------------------------------------------------------------
// Message pool queue engine
// Slot pool with a LIFO free stack and doubly linked message queues, run by
// a small sequencer around one slot-memory read port.
// ----------------------------------------------------------------------------
`default_nettype none
module message_pool_queue_engine #(
    parameter int MSG_SLOTS   = 32,
    parameter int QUEUE_COUNT = 8,
    parameter int SENDER_BITS = 8
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    // action[2:0], queue_id[5:3], slot_index[10:6], sender_id[18:11],
    // payload_in[50:19], match_any[51], zero fill to 56 bits
    input  wire  [55:0] s_tdata,
    output logic        m_tvalid,
    input  wire         m_tready,
    // ok[0], slot_out[5:1], sender_out[13:6], payload_out[45:14],
    // queue_empty[46], zero fill to 48 bits
    output logic [47:0] m_tdata
);
    import mpqe_pkg::*;

    localparam int SB  = $clog2(MSG_SLOTS);
    localparam int LB  = SB + 1;
    localparam int QB  = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
    localparam logic [LB-1:0] NIL = LB'(MSG_SLOTS);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_EXEC  = 3'd2;
    localparam logic [2:0] ST_WALK  = 3'd3;
    localparam logic [2:0] ST_FIX   = 3'd4;
    localparam logic [2:0] ST_RDOUT = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    // Slot memories: one synchronous read port each, shared by every step.
    logic [LB-1:0]          next_mem [MSG_SLOTS];
    logic [LB-1:0]          prev_mem [MSG_SLOTS];
    logic [SENDER_BITS-1:0] snd_mem  [MSG_SLOTS];
    logic [PAYLOAD_W-1:0]   pay_mem  [MSG_SLOTS];
    logic [SB-1:0]          fstack   [MSG_SLOTS];
    // Per-slot link valid bits stand in for the all-null reset of the links.
    logic [MSG_SLOTS-1:0]   nvld_reg, pvld_reg;
    logic [MSG_SLOTS-1:0]   stk_wr_reg;
    logic [LB-1:0]          qhead_reg [QUEUE_COUNT];
    logic [LB-1:0]          qtail_reg [QUEUE_COUNT];
    logic [LB-1:0]          fcnt_reg;

    logic [2:0]             state_reg;
    logic [2:0]             act_reg;
    logic                   qok_reg, sok_reg, any_reg;
    logic [QB-1:0]          q_reg;
    logic [SB-1:0]          s_reg;
    logic [SENDER_BITS-1:0] snd_reg;
    logic [PAYLOAD_W-1:0]   pay_reg;
    logic [LB-1:0]          cur_reg;
    logic [LB-1:0]          steps_reg;
    logic                   ok_reg;
    logic [SB-1:0]          found_reg;

    // Read address and registered read data.
    logic [SB-1:0]          raddr;
    logic [LB-1:0]          rd_next_reg, rd_prev_reg;
    logic [SENDER_BITS-1:0] rd_snd_reg;
    logic [PAYLOAD_W-1:0]   rd_pay_reg;
    logic [SB-1:0]          rd_stk_reg;
    logic                   rd_nv_reg, rd_pv_reg, rd_sv_reg;

    // Input field decode.
    logic [2:0]             in_act;
    logic [2:0]             in_q;
    logic [4:0]             in_slot;
    logic [7:0]             in_snd;
    logic                   in_qok, in_sok;

    assign in_act  = s_tdata[2:0];
    assign in_q    = s_tdata[5:3];
    assign in_slot = s_tdata[10:6];
    assign in_snd  = s_tdata[18:11];
    assign in_qok  = 32'(in_q) < QUEUE_COUNT;
    assign in_sok  = 32'(in_slot) < MSG_SLOTS;

    assign s_tready = (state_reg == ST_IDLE);

    logic [LB-1:0] link_n, link_p, hd, tl;
    assign link_n = rd_nv_reg ? rd_next_reg : NIL;
    assign link_p = rd_pv_reg ? rd_prev_reg : NIL;
    assign hd = qhead_reg[q_reg];
    assign tl = qtail_reg[q_reg];

    // Read address selection per step.
    always_comb begin
        raddr = s_reg;
        if (state_reg == ST_READ && act_reg == ACT_ALLOC) begin
            raddr = SB'(fcnt_reg - LB'(1));
        end else if (state_reg == ST_WALK ||
                     (state_reg == ST_READ || state_reg == ST_EXEC) && act_reg == ACT_POP) begin
            raddr = cur_reg[SB-1:0];
        end else if (state_reg == ST_RDOUT || state_reg == ST_FIX) begin
            raddr = found_reg;
        end
    end

    always_ff @(posedge aclk) begin
        rd_next_reg <= next_mem[raddr];
        rd_prev_reg <= prev_mem[raddr];
        rd_snd_reg  <= snd_mem[raddr];
        rd_pay_reg  <= pay_mem[raddr];
        rd_stk_reg  <= fstack[raddr];
        rd_nv_reg   <= nvld_reg[raddr];
        rd_pv_reg   <= pvld_reg[raddr];
        rd_sv_reg   <= stk_wr_reg[raddr];
    end

    // Sequencer and state updates.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            m_tvalid   <= 1'b0;
            fcnt_reg   <= LB'(MSG_SLOTS);
            nvld_reg   <= '0;
            pvld_reg   <= '0;
            stk_wr_reg <= '0;
            for (int i = 0; i < QUEUE_COUNT; i++) begin
                qhead_reg[i] <= NIL;
                qtail_reg[i] <= NIL;
            end
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        act_reg   <= in_act;
                        qok_reg   <= in_qok;
                        sok_reg   <= in_sok;
                        q_reg     <= in_qok ? QB'(in_q) : '0;
                        s_reg     <= in_sok ? SB'(in_slot) : '0;
                        snd_reg   <= SENDER_BITS'(in_snd);
                        pay_reg   <= s_tdata[50:19];
                        any_reg   <= s_tdata[51];
                        ok_reg    <= 1'b0;
                        found_reg <= '0;
                        steps_reg <= '0;
                        cur_reg   <= in_qok ? qhead_reg[QB'(in_q)] : NIL;
                        state_reg <= ST_READ;
                    end
                end
                ST_READ: begin
                    state_reg <= ST_EXEC;
                end
                ST_EXEC: begin
                    state_reg <= ST_RDOUT;
                    case (act_reg)
                        ACT_ALLOC: begin
                            if (fcnt_reg != '0) begin
                                fcnt_reg <= fcnt_reg - LB'(1);
                                found_reg <= rd_sv_reg ? rd_stk_reg
                                           : SB'(fcnt_reg - LB'(1));
                                ok_reg   <= 1'b1;
                                state_reg <= ST_FIX;
                            end
                        end
                        ACT_FREE: begin
                            if (sok_reg && fcnt_reg < LB'(MSG_SLOTS)) begin
                                fstack[fcnt_reg[SB-1:0]] <= s_reg;
                                stk_wr_reg[fcnt_reg[SB-1:0]] <= 1'b1;
                                fcnt_reg <= fcnt_reg + LB'(1);
                            end
                        end
                        ACT_ENQ: begin
                            if (sok_reg && qok_reg) begin
                                snd_mem[s_reg] <= snd_reg;
                                pay_mem[s_reg] <= pay_reg;
                                nvld_reg[s_reg] <= 1'b0;
                                prev_mem[s_reg] <= tl;
                                pvld_reg[s_reg] <= 1'b1;
                                found_reg <= tl[SB-1:0];
                                if (tl == NIL) qhead_reg[q_reg] <= {1'b0, s_reg};
                                qtail_reg[q_reg] <= {1'b0, s_reg};
                                if (tl != NIL) state_reg <= ST_FIX;
                            end
                        end
                        ACT_PUSH: begin
                            if (sok_reg && qok_reg) begin
                                snd_mem[s_reg] <= snd_reg;
                                pay_mem[s_reg] <= pay_reg;
                                pvld_reg[s_reg] <= 1'b0;
                                next_mem[s_reg] <= hd;
                                nvld_reg[s_reg] <= 1'b1;
                                found_reg <= hd[SB-1:0];
                                if (hd == NIL) qtail_reg[q_reg] <= {1'b0, s_reg};
                                qhead_reg[q_reg] <= {1'b0, s_reg};
                                if (hd != NIL) state_reg <= ST_FIX;
                            end
                        end
                        ACT_POP: begin
                            state_reg <= ST_WALK;
                        end
                        ACT_PEEK: begin
                            if (qok_reg && hd != NIL) begin
                                found_reg <= hd[SB-1:0];
                                ok_reg <= 1'b1;
                            end
                        end
                        ACT_QUERY: begin
                        end
                        ACT_QRST: begin
                            if (qok_reg) begin
                                qhead_reg[q_reg] <= NIL;
                                qtail_reg[q_reg] <= NIL;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                // One entry per visit, via ST_EXEC between entries: read data of cur_reg is present.
                ST_WALK: begin
                    if (cur_reg == NIL || steps_reg == LB'(MSG_SLOTS)) begin
                        state_reg <= ST_RDOUT;
                    end else if (any_reg || rd_snd_reg == snd_reg) begin
                        // Unlink the matching entry.
                        if (link_p != NIL) begin
                            next_mem[link_p[SB-1:0]] <= link_n;
                            nvld_reg[link_p[SB-1:0]] <= 1'b1;
                        end else begin
                            qhead_reg[q_reg] <= link_n;
                        end
                        if (link_n != NIL) begin
                            prev_mem[link_n[SB-1:0]] <= link_p;
                            pvld_reg[link_n[SB-1:0]] <= 1'b1;
                        end else begin
                            qtail_reg[q_reg] <= link_p;
                        end
                        nvld_reg[cur_reg[SB-1:0]] <= 1'b0;
                        pvld_reg[cur_reg[SB-1:0]] <= 1'b0;
                        found_reg <= cur_reg[SB-1:0];
                        ok_reg    <= 1'b1;
                        state_reg <= ST_RDOUT;
                    end else begin
                        cur_reg   <= link_n;
                        steps_reg <= steps_reg + LB'(1);
                        state_reg <= ST_EXEC;
                        act_reg   <= ACT_POP;
                    end
                end
                // Second write of a step: neighbor link or slot clear.
                ST_FIX: begin
                    state_reg <= ST_RDOUT;
                    if (act_reg == ACT_ENQ) begin
                        next_mem[found_reg] <= {1'b0, s_reg};
                        nvld_reg[found_reg] <= 1'b1;
                    end else if (act_reg == ACT_PUSH) begin
                        prev_mem[found_reg] <= {1'b0, s_reg};
                        pvld_reg[found_reg] <= 1'b1;
                    end else begin
                        snd_mem[found_reg] <= '0;
                        pay_mem[found_reg] <= '0;
                        nvld_reg[found_reg] <= 1'b0;
                        pvld_reg[found_reg] <= 1'b0;
                    end
                end
                ST_RDOUT: begin
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (!m_tvalid) begin
                        m_tvalid  <= 1'b1;
                        m_tdata   <= {1'b0,
                                      !(qok_reg && hd != NIL),
                                      ok_reg ? rd_pay_reg : 32'd0,
                                      ok_reg ? 8'(rd_snd_reg) : 8'd0,
                                      ok_reg ? 5'(found_reg) : 5'd0,
                                      ok_reg};
                    end else if (m_tready) begin
                        m_tvalid  <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTH
    // No new item is taken while a result is outstanding.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("ready while result pending");
    // The free count never exceeds the pool size.
    a_fcnt: assert property (@(posedge aclk) disable iff (!aresetn)
        fcnt_reg <= LB'(MSG_SLOTS)) else $error("free count overflow");
    // An accepted beat always starts with a memory read step.
    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> state_reg == ST_READ) else $error("bad start");
`endif
endmodule
`default_nettype wire
